// ===== design/mwip_pkg.sv =====
package mwip_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WHEELS        = 4;
    localparam int WHEEL_W       = 2;
    localparam int WHEEL_FL      = 0;
    localparam int WHEEL_FR      = 1;
    localparam int WHEEL_RL      = 2;
    localparam int WHEEL_RR      = 3;

    localparam int TURN_CLAMP    = 400;
    localparam int TURN_DIV      = 5;
    localparam int TURN_RECIP    = 205;
    localparam int TURN_RECIP_SH = 10;
    localparam int GAIN_SH       = 8;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int GAIN_W        = 16;
    localparam int VI_W          = 12;
    localparam int LIMIT_W       = 15;
    localparam int DRIVE_W       = 16;

    localparam logic [VI_W-1:0]    VI_SPAN_RST      = 12'd100;
    localparam logic [VI_W-1:0]    VI_FULL_BAND_RST = 12'd10;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST  = 15'd25000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_GAIN       = 3'd0,
        CFG_I_GAIN       = 3'd1,
        CFG_D_GAIN       = 3'd2,
        CFG_VI_ENABLE    = 3'd3,
        CFG_VI_SPAN      = 3'd4,
        CFG_VI_FULL_BAND = 3'd5,
        CFG_DRIVE_LIMIT  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_V
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_PM,
        S_IM,
        S_DM,
        S_DX,
        S_DIV,
        S_VM,
        S_VX,
        S_ACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     cap_in;
        logic     calc_err;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     take_p;
        logic     take_i;
        logic     take_d;
        logic     take_v;
        logic     div_start;
        logic     div_step;
        logic     acc_wr;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic last_wheel;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== design/mwip_ctrl.sv =====
module mwip_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mwip_pkg::dp_sts_t     sts,
    output mwip_pkg::ctrl_cmd_t   cmd
);

    mwip_pkg::state_t state_reg;
    mwip_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mwip_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mwip_pkg::S_IDLE: begin
                if (s_valid) state_next = mwip_pkg::S_ERR;
            end
            mwip_pkg::S_ERR: state_next = mwip_pkg::S_PM;
            mwip_pkg::S_PM:  state_next = mwip_pkg::S_IM;
            mwip_pkg::S_IM:  state_next = mwip_pkg::S_DM;
            mwip_pkg::S_DM:  state_next = mwip_pkg::S_DX;
            mwip_pkg::S_DX: begin
                state_next = sts.need_div ? mwip_pkg::S_DIV : mwip_pkg::S_ACC;
            end
            mwip_pkg::S_DIV: begin
                if (sts.div_done) state_next = mwip_pkg::S_VM;
            end
            mwip_pkg::S_VM:  state_next = mwip_pkg::S_VX;
            mwip_pkg::S_VX:  state_next = mwip_pkg::S_ACC;
            mwip_pkg::S_ACC: begin
                state_next = sts.last_wheel ? mwip_pkg::S_DONE : mwip_pkg::S_ERR;
            end
            mwip_pkg::S_DONE: begin
                if (!sts.out_busy) state_next = mwip_pkg::S_IDLE;
            end
            default: state_next = mwip_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            mwip_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.cap_in = s_valid;
            end
            mwip_pkg::S_ERR: cmd.calc_err = 1'b1;
            mwip_pkg::S_PM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mwip_pkg::MUL_P;
            end
            mwip_pkg::S_IM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mwip_pkg::MUL_I;
                cmd.take_p  = 1'b1;
            end
            mwip_pkg::S_DM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mwip_pkg::MUL_D;
                cmd.take_i  = 1'b1;
            end
            mwip_pkg::S_DX: begin
                cmd.take_d    = 1'b1;
                cmd.div_start = sts.need_div;
            end
            mwip_pkg::S_DIV: cmd.div_step = !sts.div_done;
            mwip_pkg::S_VM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mwip_pkg::MUL_V;
            end
            mwip_pkg::S_VX:  cmd.take_v = 1'b1;
            mwip_pkg::S_ACC: cmd.acc_wr = 1'b1;
            mwip_pkg::S_DONE: cmd.out_load = !sts.out_busy;
            default: cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_step_only_running: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !sts.div_done)
        else $error("divider stepped after completion");
    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_busy)
        else $error("output register overwritten while occupied");
    a_div_needed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> sts.need_div)
        else $error("division started outside the fading band");
`endif

endmodule

// ===== design/mwip_datapath.sv =====
module mwip_datapath #(
    parameter int FRAC_BITS = mwip_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mwip_pkg::ctrl_cmd_t                 cmd,
    output mwip_pkg::dp_sts_t                   sts,
    input  logic                                cfg_wr_en,
    input  logic [mwip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwip_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic signed [10:0]                  s_set_x,
    input  logic signed [10:0]                  s_set_y,
    input  logic signed [11:0]                  s_set_turn,
    input  logic signed [11:0]                  s_count_front_left,
    input  logic signed [11:0]                  s_count_front_right,
    input  logic signed [11:0]                  s_count_rear_left,
    input  logic signed [11:0]                  s_count_rear_right,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_front_right,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_front_left,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_rear_right,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_rear_left
);

    localparam int EW  = FRAC_BITS + 14;
    localparam int DW  = EW + 2;
    localparam int MA  = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
    localparam int MB  = DW + 9;
    localparam int MP  = MA + MB;
    localparam int AW  = FRAC_BITS + 16;
    localparam int SW  = MB + 2;
    localparam int NW  = FRAC_BITS + 13;
    localparam int CW  = $clog2(NW + 1);
    localparam int RW  = mwip_pkg::VI_W + 1;
    localparam int WW  = mwip_pkg::WHEEL_W;
    localparam int GW  = mwip_pkg::GAIN_W;
    localparam int DRW = mwip_pkg::DRIVE_W;

    localparam logic [FRAC_BITS-1:0] TFRAC1 = FRAC_BITS'((2 ** FRAC_BITS) / mwip_pkg::TURN_DIV);
    localparam logic [FRAC_BITS-1:0] TFRAC2 =
        FRAC_BITS'((2 * (2 ** FRAC_BITS)) / mwip_pkg::TURN_DIV);
    localparam logic [FRAC_BITS-1:0] TFRAC3 =
        FRAC_BITS'((3 * (2 ** FRAC_BITS)) / mwip_pkg::TURN_DIV);
    localparam logic [FRAC_BITS-1:0] TFRAC4 =
        FRAC_BITS'((4 * (2 ** FRAC_BITS)) / mwip_pkg::TURN_DIV);
    localparam logic signed [MP-1:0] RND8 = MP'((2 ** mwip_pkg::GAIN_SH) - 1);
    localparam logic signed [MP-1:0] RNDF = MP'((2 ** FRAC_BITS) - 1);
    localparam logic signed [AW-1:0] RNDA = AW'((2 ** FRAC_BITS) - 1);

    // Configuration registers.
    logic [GW-1:0]                   p_gain_reg, i_gain_reg, d_gain_reg;
    logic                            vi_enable_reg;
    logic [mwip_pkg::VI_W-1:0]       vi_span_reg, vi_full_band_reg;
    logic [mwip_pkg::LIMIT_W-1:0]    drive_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg       <= '0;
            i_gain_reg       <= '0;
            d_gain_reg       <= '0;
            vi_enable_reg    <= 1'b0;
            vi_span_reg      <= mwip_pkg::VI_SPAN_RST;
            vi_full_band_reg <= mwip_pkg::VI_FULL_BAND_RST;
            drive_limit_reg  <= mwip_pkg::DRIVE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (mwip_pkg::cfg_idx_t'(cfg_index))
                mwip_pkg::CFG_P_GAIN:       p_gain_reg <= cfg_wr_data[GW-1:0];
                mwip_pkg::CFG_I_GAIN:       i_gain_reg <= cfg_wr_data[GW-1:0];
                mwip_pkg::CFG_D_GAIN:       d_gain_reg <= cfg_wr_data[GW-1:0];
                mwip_pkg::CFG_VI_ENABLE:    vi_enable_reg <= cfg_wr_data[0];
                mwip_pkg::CFG_VI_SPAN:      vi_span_reg <= cfg_wr_data[mwip_pkg::VI_W-1:0];
                mwip_pkg::CFG_VI_FULL_BAND: vi_full_band_reg <= cfg_wr_data[mwip_pkg::VI_W-1:0];
                mwip_pkg::CFG_DRIVE_LIMIT:  drive_limit_reg <= cfg_wr_data[mwip_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Turn term: clamp, then magnitude/5 by reciprocal with the fraction of the remainder from a table.
    logic signed [11:0]       z_clamp;
    logic [8:0]               z_mag;
    logic [16:0]              z_prod;
    logic [6:0]               z_quo;
    logic [2:0]               z_rem;
    logic [FRAC_BITS-1:0]     t_frac;
    logic signed [EW-1:0]     t_mag, t_val;

    always_comb begin
        if (s_set_turn > 12'sd400) begin
            z_clamp = 12'sd400;
        end else if (s_set_turn < -12'sd400) begin
            z_clamp = -12'sd400;
        end else begin
            z_clamp = s_set_turn;
        end
        z_mag  = z_clamp[11] ? 9'(-z_clamp) : 9'(z_clamp);
        z_prod = 17'(z_mag) * 17'(mwip_pkg::TURN_RECIP);
        z_quo  = 7'(z_prod >> mwip_pkg::TURN_RECIP_SH);
        z_rem  = 3'(z_mag - 9'(z_quo) * 9'(mwip_pkg::TURN_DIV));
        case (z_rem)
            3'd1:    t_frac = TFRAC1;
            3'd2:    t_frac = TFRAC2;
            3'd3:    t_frac = TFRAC3;
            3'd4:    t_frac = TFRAC4;
            default: t_frac = '0;
        endcase
        t_mag = (EW'(z_quo) << FRAC_BITS) | EW'(t_frac);
        t_val = z_clamp[11] ? -t_mag : t_mag;
    end

    logic signed [10:0]    x_reg, y_reg;
    logic signed [EW-1:0]  t_reg;
    logic signed [11:0]    cnt_reg [mwip_pkg::WHEELS];
    logic [WW-1:0]         wheel_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            x_reg   <= s_set_x;
            y_reg   <= s_set_y;
            t_reg   <= t_val;
            cnt_reg[mwip_pkg::WHEEL_FL] <= s_count_front_left;
            cnt_reg[mwip_pkg::WHEEL_FR] <= s_count_front_right;
            cnt_reg[mwip_pkg::WHEEL_RL] <= s_count_rear_left;
            cnt_reg[mwip_pkg::WHEEL_RR] <= s_count_rear_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_reg <= '0;
        end else if (cmd.cap_in) begin
            wheel_reg <= '0;
        end else if (cmd.acc_wr) begin
            wheel_reg <= wheel_reg + 1'b1;
        end
    end

    // Per-wheel state.
    logic signed [EW-1:0] err1_reg [mwip_pkg::WHEELS];
    logic signed [EW-1:0] err2_reg [mwip_pkg::WHEELS];
    logic signed [AW-1:0] acc_reg  [mwip_pkg::WHEELS];

    // Error terms of the current wheel.
    logic signed [EW-1:0] x_w, y_w, set_w, cnt_w, e_w, e1_w, e2_w, mag_w;
    logic signed [DW-1:0] de_w, dd_w;
    logic [EW-1:0]        lo_w, hi_w;
    logic [12:0]          ab_w;
    logic                 mid_w, zero_w;

    always_comb begin
        e1_w  = err1_reg[wheel_reg];
        e2_w  = err2_reg[wheel_reg];
        x_w   = EW'(x_reg) <<< FRAC_BITS;
        y_w   = EW'(y_reg) <<< FRAC_BITS;
        cnt_w = EW'(cnt_reg[wheel_reg]) <<< FRAC_BITS;
        set_w = x_w;
        if (wheel_reg == WW'(mwip_pkg::WHEEL_FL) || wheel_reg == WW'(mwip_pkg::WHEEL_RR)) begin
            set_w = set_w + y_w;
        end else begin
            set_w = set_w - y_w;
        end
        if (wheel_reg[0]) begin
            set_w = set_w + t_reg;
        end else begin
            set_w = set_w - t_reg;
        end
        e_w    = set_w - cnt_w;
        de_w   = DW'(e_w) - DW'(e1_w);
        dd_w   = DW'(e_w) - (DW'(e1_w) <<< 1) + DW'(e2_w);
        mag_w  = e_w[EW-1] ? -e_w : e_w;
        ab_w   = 13'(vi_span_reg) + 13'(vi_full_band_reg);
        lo_w   = EW'(vi_full_band_reg) << FRAC_BITS;
        hi_w   = EW'(ab_w) << FRAC_BITS;
        mid_w  = (EW'(mag_w) > lo_w) && (EW'(mag_w) <= hi_w);
        zero_w = EW'(mag_w) > hi_w;
    end

    logic signed [EW-1:0] e_reg;
    logic signed [DW-1:0] de_reg, dd_reg;
    logic [NW-1:0]        num_reg;
    logic                 mid_reg, zero_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc_err) begin
            e_reg    <= e_w;
            de_reg   <= de_w;
            dd_reg   <= dd_w;
            num_reg  <= NW'(hi_w - EW'(mag_w));
            mid_reg  <= mid_w;
            zero_reg <= zero_w;
        end
    end

    // Fading factor: restoring division, one quotient bit per cycle.
    logic [NW-1:0] dq_reg;
    logic [RW-1:0] rem_reg;
    logic [CW-1:0] dcnt_reg;
    logic [RW-1:0] rem_sh;
    logic          rem_ge;

    always_comb begin
        rem_sh = {rem_reg[RW-2:0], dq_reg[NW-1]};
        rem_ge = rem_sh >= RW'(vi_span_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dq_reg  <= num_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dq_reg  <= {dq_reg[NW-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sh - RW'(vi_span_reg) : rem_sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= CW'(NW);
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // Shared multiplier with registered product.
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [MP-1:0] prod_reg;
    logic signed [MP-1:0] sh8, shf;
    logic signed [MB-1:0] p_reg, i_reg, d_reg;

    always_comb begin
        case (cmd.mul_sel)
            mwip_pkg::MUL_P: begin
                mul_a = MA'(p_gain_reg);
                mul_b = MB'(de_reg);
            end
            mwip_pkg::MUL_I: begin
                mul_a = MA'(i_gain_reg);
                mul_b = MB'(e_reg);
            end
            mwip_pkg::MUL_D: begin
                mul_a = MA'(d_gain_reg);
                mul_b = MB'(dd_reg);
            end
            default: begin
                mul_a = MA'(dq_reg[FRAC_BITS:0]);
                mul_b = i_reg;
            end
        endcase
        sh8 = (prod_reg + (prod_reg[MP-1] ? RND8 : '0)) >>> mwip_pkg::GAIN_SH;
        shf = (prod_reg + (prod_reg[MP-1] ? RNDF : '0)) >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) prod_reg <= mul_a * mul_b;
        if (cmd.take_p) p_reg <= sh8[MB-1:0];
        if (cmd.take_i) i_reg <= sh8[MB-1:0];
        if (cmd.take_d) d_reg <= sh8[MB-1:0];
        if (cmd.take_v) i_reg <= shf[MB-1:0];
    end

    // Accumulate and saturate.
    logic signed [MB-1:0] i_use;
    logic signed [SW-1:0] sum_w, lim_w;
    logic signed [AW-1:0] acc_w;

    always_comb begin
        i_use = (vi_enable_reg && zero_reg) ? '0 : i_reg;
        sum_w = SW'(acc_reg[wheel_reg]) + SW'(p_reg) + SW'(i_use) + SW'(d_reg);
        lim_w = SW'(drive_limit_reg) <<< FRAC_BITS;
        if (sum_w > lim_w) begin
            acc_w = AW'(lim_w);
        end else if (sum_w < -lim_w) begin
            acc_w = AW'(-lim_w);
        end else begin
            acc_w = AW'(sum_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < mwip_pkg::WHEELS; w++) begin
                err1_reg[w] <= '0;
                err2_reg[w] <= '0;
                acc_reg[w]  <= '0;
            end
        end else if (cmd.acc_wr) begin
            err1_reg[wheel_reg] <= e_reg;
            err2_reg[wheel_reg] <= err1_reg[wheel_reg];
            acc_reg[wheel_reg]  <= acc_w;
        end
    end

    // Output register.
    logic signed [AW-1:0]  drv_w [mwip_pkg::WHEELS];
    logic signed [DRW-1:0] drive_reg [mwip_pkg::WHEELS];
    logic                  m_valid_reg;

    always_comb begin
        for (int w = 0; w < mwip_pkg::WHEELS; w++) begin
            drv_w[w] = (acc_reg[w] + (acc_reg[w][AW-1] ? RNDA : '0)) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            for (int w = 0; w < mwip_pkg::WHEELS; w++) begin
                drive_reg[w] <= drv_w[w][DRW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_drive_front_right = drive_reg[mwip_pkg::WHEEL_FR];
    assign m_drive_front_left  = drive_reg[mwip_pkg::WHEEL_FL];
    assign m_drive_rear_right  = drive_reg[mwip_pkg::WHEEL_RR];
    assign m_drive_rear_left   = drive_reg[mwip_pkg::WHEEL_RL];

    assign sts.need_div   = vi_enable_reg && mid_reg;
    assign sts.div_done   = (dcnt_reg == '0);
    assign sts.last_wheel = (wheel_reg == WW'(mwip_pkg::WHEELS - 1));
    assign sts.out_busy   = m_valid_reg && !m_ready;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded word not presented");
`endif

endmodule

// ===== design/mecanum_wheel_incremental_pid_core.sv =====
// Channel   Handshake          Word
// s_        s_valid/s_ready    body velocity set and four encoder counts
// m_        m_valid/m_ready    four saturated wheel drives
// cfg_      cfg_wr_en          register index and write data, no wait
//
// Each word runs wheel by wheel through the states ERR, PM, IM, DM, DX and ACC; a wheel
// whose error lies in the fading band with variable integral on also passes through DIV
// (NW = FRAC_BITS + 13 quotient bits), VM and VX; capture comes first, output last.
// The shared multiplier and the bit-serial divider set this sequence of states.
// Reset is synchronous and resets the controller, config registers and wheel state.
// A new word is taken while the previous result waits on m_ready.
module mecanum_wheel_incremental_pid_core #(
    parameter int FRAC_BITS = mwip_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [10:0]                  s_set_x,
    input  logic signed [10:0]                  s_set_y,
    input  logic signed [11:0]                  s_set_turn,
    input  logic signed [11:0]                  s_count_front_left,
    input  logic signed [11:0]                  s_count_front_right,
    input  logic signed [11:0]                  s_count_rear_left,
    input  logic signed [11:0]                  s_count_rear_right,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_front_right,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_front_left,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_rear_right,
    output logic signed [mwip_pkg::DRIVE_W-1:0] m_drive_rear_left,
    input  logic                                cfg_wr_en,
    input  logic [mwip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwip_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    mwip_pkg::ctrl_cmd_t cmd;
    mwip_pkg::dp_sts_t   sts;

    mwip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mwip_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_set_x             (s_set_x),
        .s_set_y             (s_set_y),
        .s_set_turn          (s_set_turn),
        .s_count_front_left  (s_count_front_left),
        .s_count_front_right (s_count_front_right),
        .s_count_rear_left   (s_count_rear_left),
        .s_count_rear_right  (s_count_rear_right),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_drive_front_right (m_drive_front_right),
        .m_drive_front_left  (m_drive_front_left),
        .m_drive_rear_right  (m_drive_rear_right),
        .m_drive_rear_left   (m_drive_rear_left)
    );

endmodule
